/* sv/lens_distortion_point_map_macros.svh */
// Assertion helpers; all assume a clock named clk and an active-low reset rst_n.
`ifndef LENS_DISTORTION_POINT_MAP_MACROS_SVH
`define LENS_DISTORTION_POINT_MAP_MACROS_SVH
`ifndef SYNTHESIS
`define LDPM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ldpm check failed");
`define LDPM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ldpm check failed");
`else
`define LDPM_ASSERT_IMP(label, ante, cons)
`define LDPM_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* sv/ldpm_pkg.sv */
package ldpm_pkg;

    localparam int PW    = 16;          // pixel coordinate, Q12.4
    localparam int FW    = 24;          // focal length, Q16.8
    localparam int CW    = 32;          // coefficient, Q4.28
    localparam int VW    = 48;          // internal value, 28 fraction bits
    localparam int MW    = VW - 1;      // internal magnitude
    localparam int FRAC  = 28;
    localparam int PIXSH = 32;
    localparam int DW    = PW + 2;      // pixel minus principal point
    localparam int MAGW  = PW + 1;
    localparam int NSH   = 32;          // normalization pre-scale
    localparam int NUMW  = MAGW + NSH;  // dividend width

    localparam int DIV_STEPS   = NUMW;
    localparam int POST_STAGES = 24;
    localparam int NSTAGES     = 1 + DIV_STEPS + POST_STAGES;

    localparam logic signed [VW-1:0] LIM = {1'b0, {MW{1'b1}}};

    localparam logic [FW-1:0] FOCAL_RESET = FW'(128000);
    localparam logic [CW-1:0] PP_RESET    = CW'(251663360);

    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_PRINCIPAL = 3'd2,
        REG_K1        = 3'd3,
        REG_K2        = 3'd4,
        REG_K3        = 3'd5,
        REG_P1        = 3'd6,
        REG_P2        = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [PW-1:0] px_in;
        logic signed [PW-1:0] py_in;
    } pt_in_t;

    typedef struct packed {
        logic signed [PW-1:0] px_out;
        logic signed [PW-1:0] py_out;
        logic                 clipped;
    } pt_out_t;

    typedef struct packed {
        logic signed [VW-1:0] v;
        logic                 ov;
    } sval_t;

    typedef struct packed {
        logic signed [PW-1:0] v;
        logic                 ov;
    } pix_t;

    function automatic sval_t sat_clamp(input logic signed [VW:0] s);
        sval_t r;
        r.ov = 1'b0;
        if (s > (VW+1)'(LIM))
        begin
            r.v  = LIM;
            r.ov = 1'b1;
        end
        else if (s < -(VW+1)'(LIM))
        begin
            r.v  = -LIM;
            r.ov = 1'b1;
        end
        else
        begin
            r.v = VW'(s);
        end
        return r;
    endfunction

    function automatic sval_t sat_add(input logic signed [VW-1:0] a,
                                      input logic signed [VW-1:0] b);
        logic signed [VW:0] s;
        s = (VW+1)'(a) + (VW+1)'(b);
        return sat_clamp(s);
    endfunction

    function automatic sval_t sat_dbl(input logic signed [VW-1:0] a);
        logic signed [VW:0] s;
        s = (VW+1)'(a) <<< 1;
        return sat_clamp(s);
    endfunction

    // scaled value plus principal point, clamped to Q12.4
    function automatic pix_t sat_pix(input logic signed [VW-1:0] a,
                                     input logic [PW-1:0] c);
        logic signed [VW:0] s;
        pix_t r;
        s = (VW+1)'(a) + (VW+1)'($signed({1'b0, c}));
        r.ov = 1'b0;
        if (s > (VW+1)'(32767))
        begin
            r.v  = PW'(32767);
            r.ov = 1'b1;
        end
        else if (s < -(VW+1)'(32768))
        begin
            r.v  = PW'(-32768);
            r.ov = 1'b1;
        end
        else
        begin
            r.v = PW'(s);
        end
        return r;
    endfunction

endpackage

/* sv/lens_distortion_point_map.sv */
// A transaction accepted at one edge passes 1 entry stage, 49 divider steps and
// 24 arithmetic stages on its way to the output, one result per clock.
// Throughput is one point per cycle: the normalizing divider retires one quotient
// bit per stage and every multiplier is a 3-stage pipe; the whole pipe stalls
// only while the output register holds an untaken result.
// Reset (async, active low) clears all valid bits and loads default config.
`include "lens_distortion_point_map_macros.svh"

module lens_distortion_point_map
    import ldpm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pt_in_t        in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output pt_out_t       out_data,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [CW-1:0] cfg_data
);

    // configuration
    logic [FW-1:0]        focal_x_reg, focal_y_reg;
    logic [CW-1:0]        principal_reg;
    logic signed [CW-1:0] k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;
    logic [FW-1:0]        fx_eff, fy_eff;
    logic [PW-1:0]        cx, cy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg   <= FOCAL_RESET;
            focal_y_reg   <= FOCAL_RESET;
            principal_reg <= PP_RESET;
            k1_reg        <= '0;
            k2_reg        <= '0;
            k3_reg        <= '0;
            p1_reg        <= '0;
            p2_reg        <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_FOCAL_X:   focal_x_reg   <= cfg_data[FW-1:0];
                REG_FOCAL_Y:   focal_y_reg   <= cfg_data[FW-1:0];
                REG_PRINCIPAL: principal_reg <= cfg_data;
                REG_K1:        k1_reg        <= cfg_data;
                REG_K2:        k2_reg        <= cfg_data;
                REG_K3:        k3_reg        <= cfg_data;
                REG_P1:        p1_reg        <= cfg_data;
                REG_P2:        p2_reg        <= cfg_data;
                default:       ;
            endcase
        end
    end

    // a zero focal length behaves as one LSB
    assign fx_eff = (focal_x_reg == '0) ? FW'(1) : focal_x_reg;
    assign fy_eff = (focal_y_reg == '0) ? FW'(1) : focal_y_reg;
    assign cx     = principal_reg[PW-1:0];
    assign cy     = principal_reg[CW-1:PW];

    // flow control: global stall when the output register is held
    logic [NSTAGES-1:0] vld_reg, vld_next;
    logic               adv;

    assign adv       = !vld_reg[NSTAGES-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NSTAGES-1];
    assign vld_next  = {vld_reg[NSTAGES-2:0], in_valid & adv};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // entry stage: offset from principal point, build dividend
    logic signed [DW-1:0] dx, dy;
    logic [MAGW-1:0]      magx, magy;

    always_comb
    begin
        dx   = DW'(in_data.px_in) - DW'($signed({1'b0, cx}));
        dy   = DW'(in_data.py_in) - DW'($signed({1'b0, cy}));
        magx = dx[DW-1] ? MAGW'(-dx) : MAGW'(dx);
        magy = dy[DW-1] ? MAGW'(-dy) : MAGW'(dy);
    end

    // restoring divider, one quotient bit per stage; quotient shifts into num
    logic [NUMW-1:0] dnx_reg [0:DIV_STEPS];
    logic [NUMW-1:0] dny_reg [0:DIV_STEPS];
    logic [FW-1:0]   drx_reg [0:DIV_STEPS];
    logic [FW-1:0]   dry_reg [0:DIV_STEPS];
    logic            dsx_reg [0:DIV_STEPS];
    logic            dsy_reg [0:DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dnx_reg[0] <= {magx, NSH'(fx_eff >> 1)};
            dny_reg[0] <= {magy, NSH'(fy_eff >> 1)};
            drx_reg[0] <= '0;
            dry_reg[0] <= '0;
            dsx_reg[0] <= dx[DW-1];
            dsy_reg[0] <= dy[DW-1];
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [FW:0]     trial_x, trial_y;
        logic            ge_x, ge_y;
        logic [FW-1:0]   remx_next, remy_next;

        always_comb
        begin
            trial_x   = {drx_reg[k], dnx_reg[k][NUMW-1]};
            trial_y   = {dry_reg[k], dny_reg[k][NUMW-1]};
            ge_x      = trial_x >= {1'b0, fx_eff};
            ge_y      = trial_y >= {1'b0, fy_eff};
            remx_next = ge_x ? FW'(trial_x - {1'b0, fx_eff}) : trial_x[FW-1:0];
            remy_next = ge_y ? FW'(trial_y - {1'b0, fy_eff}) : trial_y[FW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                drx_reg[k+1] <= remx_next;
                dry_reg[k+1] <= remy_next;
                dnx_reg[k+1] <= {dnx_reg[k][NUMW-2:0], ge_x};
                dny_reg[k+1] <= {dny_reg[k][NUMW-2:0], ge_y};
                dsx_reg[k+1] <= dsx_reg[k];
                dsy_reg[k+1] <= dsy_reg[k];
            end
        end
    end

    // t0: saturate quotient, apply sign
    logic            qx_over, qy_over;
    logic [MW-1:0]   qx_mag, qy_mag;
    logic signed [VW-1:0] x0_next, y0_next;

    always_comb
    begin
        qx_over = |dnx_reg[DIV_STEPS][NUMW-1:MW];
        qy_over = |dny_reg[DIV_STEPS][NUMW-1:MW];
        qx_mag  = qx_over ? LIM[MW-1:0] : dnx_reg[DIV_STEPS][MW-1:0];
        qy_mag  = qy_over ? LIM[MW-1:0] : dny_reg[DIV_STEPS][MW-1:0];
        x0_next = dsx_reg[DIV_STEPS] ? (VW'(0) - VW'(qx_mag)) : VW'(qx_mag);
        y0_next = dsy_reg[DIV_STEPS] ? (VW'(0) - VW'(qy_mag)) : VW'(qy_mag);
    end

    // arithmetic pipe, register names carry their stage number
    logic signed [VW-1:0] xd_reg [0:17];
    logic signed [VW-1:0] yd_reg [0:17];
    logic signed [VW-1:0] r2_reg, dxx_reg, dyy_reg, ax_reg, ay_reg;
    logic signed [VW-1:0] xy2_reg [4:5];
    logic signed [VW-1:0] r2d_reg [5:7];
    logic signed [VW-1:0] k1d_reg [8:10];
    logic signed [VW-1:0] s12_reg [11:13];
    logic signed [VW-1:0] tx_reg [9:18];
    logic signed [VW-1:0] ty_reg [9:18];
    logic signed [VW-1:0] rad_reg, sa_reg, sb_reg, sx_reg, sy_reg;
    logic signed [PW-1:0] pxo_reg, pyo_reg;
    logic [POST_STAGES-1:0] ovp_reg, ovp_next, ovin;

    logic signed [VW-1:0] k1w, k2w, k3w, p1w, p2w, fxw, fyw;
    assign k1w = VW'(k1_reg);
    assign k2w = VW'(k2_reg);
    assign k3w = VW'(k3_reg);
    assign p1w = VW'(p1_reg);
    assign p2w = VW'(p2_reg);
    assign fxw = VW'(fx_eff);
    assign fyw = VW'(fy_eff);

    logic signed [VW-1:0] xx_p, yy_p, xy_p, r4_p, k1r2_p, t1_p, t2_p, t3_p, t4_p;
    logic signed [VW-1:0] r6_p, k2r4_p, k3r6_p, xr_p, yr_p, fxs_p, fys_p;
    logic xx_o, yy_o, xy_o, r4_o, k1r2_o, t1_o, t2_o, t3_o, t4_o;
    logic r6_o, k2r4_o, k3r6_o, xr_o, yr_o, fxs_o, fys_o;

    // t0 -> t3
    ldpm_mul u_xx (.clk, .en(adv), .wide(1'b0), .a(xd_reg[0]), .b(xd_reg[0]),
                   .p(xx_p), .ov(xx_o));
    ldpm_mul u_yy (.clk, .en(adv), .wide(1'b0), .a(yd_reg[0]), .b(yd_reg[0]),
                   .p(yy_p), .ov(yy_o));
    ldpm_mul u_xy (.clk, .en(adv), .wide(1'b0), .a(xd_reg[0]), .b(yd_reg[0]),
                   .p(xy_p), .ov(xy_o));
    // t4 -> t7
    ldpm_mul u_r4 (.clk, .en(adv), .wide(1'b0), .a(r2_reg), .b(r2_reg),
                   .p(r4_p), .ov(r4_o));
    ldpm_mul u_k1 (.clk, .en(adv), .wide(1'b0), .a(k1w), .b(r2_reg),
                   .p(k1r2_p), .ov(k1r2_o));
    // t5 -> t8, tangential terms
    ldpm_mul u_t1 (.clk, .en(adv), .wide(1'b0), .a(p1w), .b(xy2_reg[5]),
                   .p(t1_p), .ov(t1_o));
    ldpm_mul u_t2 (.clk, .en(adv), .wide(1'b0), .a(p2w), .b(ax_reg),
                   .p(t2_p), .ov(t2_o));
    ldpm_mul u_t3 (.clk, .en(adv), .wide(1'b0), .a(p1w), .b(ay_reg),
                   .p(t3_p), .ov(t3_o));
    ldpm_mul u_t4 (.clk, .en(adv), .wide(1'b0), .a(p2w), .b(xy2_reg[5]),
                   .p(t4_p), .ov(t4_o));
    // t7 -> t10
    ldpm_mul u_r6 (.clk, .en(adv), .wide(1'b0), .a(r4_p), .b(r2d_reg[7]),
                   .p(r6_p), .ov(r6_o));
    ldpm_mul u_k2 (.clk, .en(adv), .wide(1'b0), .a(k2w), .b(r4_p),
                   .p(k2r4_p), .ov(k2r4_o));
    // t10 -> t13
    ldpm_mul u_k3 (.clk, .en(adv), .wide(1'b0), .a(k3w), .b(r6_p),
                   .p(k3r6_p), .ov(k3r6_o));
    // t14 -> t17
    ldpm_mul u_xr (.clk, .en(adv), .wide(1'b0), .a(xd_reg[14]), .b(rad_reg),
                   .p(xr_p), .ov(xr_o));
    ldpm_mul u_yr (.clk, .en(adv), .wide(1'b0), .a(yd_reg[14]), .b(rad_reg),
                   .p(yr_p), .ov(yr_o));
    // t19 -> t22, back to pixels
    ldpm_mul u_fx (.clk, .en(adv), .wide(1'b1), .a(fxw), .b(sx_reg),
                   .p(fxs_p), .ov(fxs_o));
    ldpm_mul u_fy (.clk, .en(adv), .wide(1'b1), .a(fyw), .b(sy_reg),
                   .p(fys_p), .ov(fys_o));

    sval_t r2_next, xy2_next, dxx_next, dyy_next, ax_next, ay_next;
    sval_t tx_next, ty_next, s12_next, rad_next, sa_next, sb_next, sx_next, sy_next;
    pix_t  pxo_next, pyo_next;

    always_comb
    begin
        r2_next  = sat_add(xx_p, yy_p);
        xy2_next = sat_dbl(xy_p);
        dxx_next = sat_dbl(xx_p);
        dyy_next = sat_dbl(yy_p);
        ax_next  = sat_add(r2_reg, dxx_reg);
        ay_next  = sat_add(r2_reg, dyy_reg);
        tx_next  = sat_add(t1_p, t2_p);
        ty_next  = sat_add(t3_p, t4_p);
        s12_next = sat_add(k1d_reg[10], k2r4_p);
        rad_next = sat_add(s12_reg[13], k3r6_p);
        sa_next  = sat_add(xd_reg[17], xr_p);
        sb_next  = sat_add(yd_reg[17], yr_p);
        sx_next  = sat_add(sa_reg, tx_reg[18]);
        sy_next  = sat_add(sb_reg, ty_reg[18]);
        pxo_next = sat_pix(fxs_p, cx);
        pyo_next = sat_pix(fys_p, cy);

        ovin     = '0;
        ovin[0]  = qx_over | qy_over;
        ovin[4]  = xx_o | yy_o | xy_o | r2_next.ov | xy2_next.ov | dxx_next.ov
                 | dyy_next.ov;
        ovin[5]  = ax_next.ov | ay_next.ov;
        ovin[8]  = r4_o | k1r2_o;
        ovin[9]  = t1_o | t2_o | t3_o | t4_o | tx_next.ov | ty_next.ov;
        ovin[11] = r6_o | k2r4_o | s12_next.ov;
        ovin[14] = k3r6_o | rad_next.ov;
        ovin[18] = xr_o | yr_o | sa_next.ov | sb_next.ov;
        ovin[19] = sx_next.ov | sy_next.ov;
        ovin[23] = fxs_o | fys_o | pxo_next.ov | pyo_next.ov;

        ovp_next = ovin | {ovp_reg[POST_STAGES-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xd_reg[0] <= x0_next;
            yd_reg[0] <= y0_next;
            for (int i = 1; i <= 17; i++)
            begin
                xd_reg[i] <= xd_reg[i-1];
                yd_reg[i] <= yd_reg[i-1];
            end
            r2_reg      <= r2_next.v;
            xy2_reg[4]  <= xy2_next.v;
            xy2_reg[5]  <= xy2_reg[4];
            dxx_reg     <= dxx_next.v;
            dyy_reg     <= dyy_next.v;
            ax_reg      <= ax_next.v;
            ay_reg      <= ay_next.v;
            r2d_reg[5]  <= r2_reg;
            r2d_reg[6]  <= r2d_reg[5];
            r2d_reg[7]  <= r2d_reg[6];
            k1d_reg[8]  <= k1r2_p;
            k1d_reg[9]  <= k1d_reg[8];
            k1d_reg[10] <= k1d_reg[9];
            tx_reg[9]   <= tx_next.v;
            ty_reg[9]   <= ty_next.v;
            for (int i = 10; i <= 18; i++)
            begin
                tx_reg[i] <= tx_reg[i-1];
                ty_reg[i] <= ty_reg[i-1];
            end
            s12_reg[11] <= s12_next.v;
            s12_reg[12] <= s12_reg[11];
            s12_reg[13] <= s12_reg[12];
            rad_reg     <= rad_next.v;
            sa_reg      <= sa_next.v;
            sb_reg      <= sb_next.v;
            sx_reg      <= sx_next.v;
            sy_reg      <= sy_next.v;
            pxo_reg     <= pxo_next.v;
            pyo_reg     <= pyo_next.v;
            ovp_reg     <= ovp_next;
        end
    end

    always_comb
    begin
        out_data.px_out  = pxo_reg;
        out_data.py_out  = pyo_reg;
        out_data.clipped = ovp_reg[POST_STAGES-1];
    end

    // divider remainder always ends below the divisor
    `LDPM_ASSERT_IMP(a_div_rem, vld_reg[DIV_STEPS], drx_reg[DIV_STEPS] < fx_eff)
    // a held output freezes every stage
    `LDPM_ASSERT_NXT(a_stall_hold, !adv, $stable(vld_reg))
    // quotient overflow must reach the clip flag chain
    `LDPM_ASSERT_NXT(a_norm_flag, vld_reg[DIV_STEPS] && adv && (qx_over || qy_over),
                     ovp_reg[0])

endmodule

/* sv/ldpm_mul.sv */
// Signed-magnitude multiply, rounded half away from zero, saturated to +-LIM.
// Three stages: partial products, sum, round/shift/saturate.
module ldpm_mul
    import ldpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic                 wide,
    input  logic signed [VW-1:0] a,
    input  logic signed [VW-1:0] b,
    output logic signed [VW-1:0] p,
    output logic                 ov
);

    localparam int HW  = 24;
    localparam int UW  = MW - HW;
    localparam int PRW = 2 * MW;
    localparam logic [PRW:0] LIMU = (PRW+1)'(LIM);

    logic [MW-1:0]     ma, mb;
    logic [2*HW-1:0]   ll_next, ll_reg;
    logic [MW-1:0]     lh_next, lh_reg, hl_next, hl_reg;
    logic [2*UW-1:0]   hh_next, hh_reg;
    logic              neg1_reg, wide1_reg, neg2_reg, wide2_reg;
    logic [PRW-1:0]    prod_next, prod_reg;
    logic [PRW:0]      rnd, shd;
    logic [MW-1:0]     mres;
    logic              sat;
    logic signed [VW-1:0] p_next;
    logic signed [VW-1:0] p_reg;
    logic              ov_reg;

    always_comb
    begin
        ma      = a[VW-1] ? MW'(-a) : MW'(a);
        mb      = b[VW-1] ? MW'(-b) : MW'(b);
        ll_next = ma[HW-1:0] * mb[HW-1:0];
        lh_next = ma[HW-1:0] * mb[MW-1:HW];
        hl_next = ma[MW-1:HW] * mb[HW-1:0];
        hh_next = ma[MW-1:HW] * mb[MW-1:HW];
    end

    always_comb
    begin
        prod_next = PRW'(ll_reg) + (PRW'(lh_reg) << HW) + (PRW'(hl_reg) << HW)
                  + (PRW'(hh_reg) << (2 * HW));
    end

    always_comb
    begin
        rnd  = (PRW+1)'(prod_reg) + (wide2_reg ? ((PRW+1)'(1) << (PIXSH - 1))
                                               : ((PRW+1)'(1) << (FRAC - 1)));
        shd  = wide2_reg ? (rnd >> PIXSH) : (rnd >> FRAC);
        sat  = shd > LIMU;
        mres = sat ? LIM[MW-1:0] : shd[MW-1:0];
        p_next = neg2_reg ? (VW'(0) - VW'(mres)) : VW'(mres);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg    <= ll_next;
            lh_reg    <= lh_next;
            hl_reg    <= hl_next;
            hh_reg    <= hh_next;
            neg1_reg  <= a[VW-1] ^ b[VW-1];
            wide1_reg <= wide;
            prod_reg  <= prod_next;
            neg2_reg  <= neg1_reg;
            wide2_reg <= wide1_reg;
            p_reg     <= p_next;
            ov_reg    <= sat;
        end
    end

    assign p  = p_reg;
    assign ov = ov_reg;

endmodule
